// ===== src/cxrms_pkg.sv =====
// ----------------------------------------------------------------------------
// cxrms_pkg
// Shared constants, result codes and controller/datapath signal bundles.
// ----------------------------------------------------------------------------
package cxrms_pkg;

  localparam int unsigned ROWS_MAX   = 16;
  localparam int unsigned ROW_W      = $clog2(ROWS_MAX);
  localparam int unsigned CNT_W      = 5;   // width of rows_in_use
  localparam int unsigned COL_W      = 8;
  localparam int unsigned DATA_W     = 16;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SS_W       = 35;  // sum of up to 16 squares of Q8.8
  localparam int unsigned RS_W       = 21;
  localparam int unsigned DIV_NUM_W  = 36;
  localparam int unsigned DIV_DEN_W  = 17;
  localparam int unsigned DIV_STEPS  = DIV_NUM_W / 2;  // two quotient bits a cycle
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int unsigned SQ_W       = 31;  // mean square is at most 2^30
  localparam int unsigned SQ_STEPS   = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;
  localparam logic [CNT_W-1:0] ROWS_RESET = 5'd16;
  localparam logic [COL_W-1:0] COLS_RESET = 8'd1;

  localparam logic [DATA_W-1:0] ONE_Q88 = 16'h0100;

  localparam logic [KIND_W-1:0] KIND_ELEM  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SCALE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RESP  = 2'd2;

  localparam logic [1:0] DIV_MS   = 2'd0;
  localparam logic [1:0] DIV_ELEM = 2'd1;
  localparam logic [1:0] DIV_MEAN = 2'd2;

  typedef struct packed {
    logic              accept;
    logic              div_start;
    logic [1:0]        div_sel;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              sqrt_round;
    logic              emit;
    logic [KIND_W-1:0] emit_kind;
    logic              emit_last;
    logic [ROW_W-1:0]  row;
    logic              col_done;
  } cmd_t;

  typedef struct packed {
    logic             ends_col;
    logic             col_zero;
    logic             zero_scale;
    logic             div_done;
    logic             out_free;
    logic [ROW_W-1:0] m_last;
  } sts_t;

endpackage

// ===== src/column_rms_scale_and_center_top.sv =====
// ----------------------------------------------------------------------------
// column_rms_scale_and_center_top
// Column RMS normalisation of a streamed matrix with response centring.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-------------------------------
//  in      | sink      | in_valid_i / in_stall_o | x_sample, y_sample
//  out     | source    | out_valid_o/out_stall_i | kind, value, column/row index,
//          |           |                         | zero_scale, intercept, last
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A beat that does not close a column is taken at once and intake stays open.
//  A closing beat holds intake while the column is finished: one divide for the
//  mean square, the square root, one divide per element (none when the scale is
//  zero) and, after column zero, one divide for the mean; every result may also
//  wait on out_stall_i. The shared two-bit-per-cycle divider sets the cost.
//  Intake reopens once the final result of a column sits in the output
//  register, so the next beat can arrive while that result is stalled.
//  Reset is asynchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module column_rms_scale_and_center_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // sample channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [cxrms_pkg::DATA_W-1:0]  in_x_sample_i,
  input  logic signed [cxrms_pkg::DATA_W-1:0]  in_y_sample_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [cxrms_pkg::KIND_W-1:0]         out_kind_o,
  output logic signed [cxrms_pkg::DATA_W-1:0]  out_value_o,
  output logic [cxrms_pkg::COL_W-1:0]          out_column_index_o,
  output logic [cxrms_pkg::CNT_W-1:0]          out_row_index_o,
  output logic                                 out_zero_scale_o,
  output logic                                 out_intercept_found_o,
  output logic                                 out_last_result_o,
  // register writes
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [cxrms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cxrms_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  cxrms_pkg::cmd_t cmd;
  cxrms_pkg::sts_t sts;

  // registers can always be written; the user is to write them only while idle, as the block does not enforce it
  assign cfg_ready_o = 1'b1;

  cxrms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  cxrms_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .x_i         (in_x_sample_i),
    .y_i         (in_y_sample_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_kind_o  (out_kind_o),
    .out_value_o (out_value_o),
    .out_col_o   (out_column_index_o),
    .out_row_o   (out_row_index_o),
    .out_zs_o    (out_zero_scale_o),
    .out_icp_o   (out_intercept_found_o),
    .out_last_o  (out_last_result_o)
  );

endmodule

// ===== src/cxrms_div.sv =====
// ----------------------------------------------------------------------------
// cxrms_div
// Unsigned restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module cxrms_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [cxrms_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [cxrms_pkg::DIV_DEN_W-1:0]     den_i,
  output logic                                done_o,
  output logic [cxrms_pkg::DIV_NUM_W-1:0]     quo_o
);

  logic [cxrms_pkg::DIV_NUM_W-1:0] num_q, num_d;
  logic [cxrms_pkg::DIV_DEN_W-1:0] den_q;
  logic [cxrms_pkg::DIV_DEN_W-1:0] rem_q, rem_d;
  logic [cxrms_pkg::DIV_CNT_W-1:0] cnt_q;
  logic                            busy_q, done_q;

  logic [cxrms_pkg::DIV_DEN_W:0]   t1, t2;
  logic [cxrms_pkg::DIV_DEN_W-1:0] r1;
  logic                            g1, g2;

  always_comb begin
    t1 = {rem_q, num_q[cxrms_pkg::DIV_NUM_W-1]};
    g1 = (t1 >= {1'b0, den_q});
    r1 = g1 ? cxrms_pkg::DIV_DEN_W'(t1 - {1'b0, den_q}) : t1[cxrms_pkg::DIV_DEN_W-1:0];
    t2 = {r1, num_q[cxrms_pkg::DIV_NUM_W-2]};
    g2 = (t2 >= {1'b0, den_q});
    rem_d = g2 ? cxrms_pkg::DIV_DEN_W'(t2 - {1'b0, den_q}) : t2[cxrms_pkg::DIV_DEN_W-1:0];
    num_d = {num_q[cxrms_pkg::DIV_NUM_W-3:0], g1, g2};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == cxrms_pkg::DIV_CNT_W'(cxrms_pkg::DIV_STEPS - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = num_q;

endmodule

// ===== src/cxrms_dp.sv =====
// ----------------------------------------------------------------------------
// cxrms_dp
// Datapath: buffers, running sums, square root, shared divider, result reg.
// ----------------------------------------------------------------------------
module cxrms_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  cxrms_pkg::cmd_t                      cmd_i,
  output cxrms_pkg::sts_t                      sts_o,
  input  logic                                 cfg_we_i,
  input  logic [cxrms_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cxrms_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic signed [cxrms_pkg::DATA_W-1:0]  x_i,
  input  logic signed [cxrms_pkg::DATA_W-1:0]  y_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [cxrms_pkg::KIND_W-1:0]         out_kind_o,
  output logic signed [cxrms_pkg::DATA_W-1:0]  out_value_o,
  output logic [cxrms_pkg::COL_W-1:0]          out_col_o,
  output logic [cxrms_pkg::CNT_W-1:0]          out_row_o,
  output logic                                 out_zs_o,
  output logic                                 out_icp_o,
  output logic                                 out_last_o
);

  // configuration
  logic [cxrms_pkg::CNT_W-1:0] rows_q;
  logic [cxrms_pkg::COL_W-1:0] cols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= cxrms_pkg::ROWS_RESET;
      cols_q <= cxrms_pkg::COLS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        cxrms_pkg::CFG_ROWS: rows_q <= cfg_data_i[cxrms_pkg::CNT_W-1:0];
        cxrms_pkg::CFG_COLS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [cxrms_pkg::CNT_W-1:0] n_eff;
  logic [cxrms_pkg::COL_W-1:0] p_eff;
  always_comb begin
    n_eff = rows_q;
    if (rows_q == '0) n_eff = cxrms_pkg::CNT_W'(1);
    if (rows_q > cxrms_pkg::CNT_W'(cxrms_pkg::ROWS_MAX))
      n_eff = cxrms_pkg::CNT_W'(cxrms_pkg::ROWS_MAX);
    p_eff = (cols_q == '0) ? cxrms_pkg::COL_W'(1) : cols_q;
  end

  // position and accumulation state
  logic [cxrms_pkg::ROW_W-1:0]       row_q;
  logic [cxrms_pkg::COL_W-1:0]       col_q;
  logic [cxrms_pkg::SS_W-1:0]        ss_q;
  logic signed [cxrms_pkg::RS_W-1:0] rs_q;
  logic                              ones_q;
  logic signed [cxrms_pkg::DATA_W-1:0] xbuf_q [cxrms_pkg::ROWS_MAX];
  logic signed [cxrms_pkg::DATA_W-1:0] ybuf_q [cxrms_pkg::ROWS_MAX];

  logic [cxrms_pkg::CNT_W-1:0]       m;
  logic                              ends_col;
  logic signed [2*cxrms_pkg::DATA_W-1:0] sq;
  logic                              col_zero;

  assign m        = {1'b0, row_q} + cxrms_pkg::CNT_W'(1);
  assign ends_col = (m >= n_eff);
  assign sq       = x_i * x_i;
  assign col_zero = (col_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      ss_q   <= '0;
      rs_q   <= '0;
      ones_q <= 1'b1;
    end else if (cmd_i.accept) begin
      ss_q <= ss_q + {4'd0, sq[2*cxrms_pkg::DATA_W-2:0]};
      if (col_zero) begin
        rs_q <= rs_q + {{(cxrms_pkg::RS_W-cxrms_pkg::DATA_W){y_i[cxrms_pkg::DATA_W-1]}}, y_i};
        if (x_i != cxrms_pkg::ONE_Q88) ones_q <= 1'b0;
      end
      if (!ends_col) row_q <= row_q + 1'b1;
    end else if (cmd_i.col_done) begin
      ss_q  <= '0;
      row_q <= '0;
      col_q <= ({1'b0, col_q} + 9'd1 >= {1'b0, p_eff}) ? '0 : col_q + 1'b1;
      if (col_zero) begin
        rs_q   <= '0;
        ones_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      xbuf_q[row_q] <= x_i;
      if (col_zero) ybuf_q[row_q] <= y_i;
    end
  end

  // shared divider
  logic                              div_done;
  logic [cxrms_pkg::DIV_NUM_W-1:0]   quo;
  logic [cxrms_pkg::DIV_NUM_W-1:0]   div_num;
  logic [cxrms_pkg::DIV_DEN_W-1:0]   div_den;
  logic signed [cxrms_pkg::DATA_W-1:0] xr, yr;
  logic [cxrms_pkg::DATA_W-1:0]      xmag;
  logic [cxrms_pkg::RS_W-1:0]        rmag;
  logic [cxrms_pkg::DATA_W-1:0]      scale_q;

  assign xr   = xbuf_q[cmd_i.row];
  assign yr   = ybuf_q[cmd_i.row];
  assign xmag = xr[cxrms_pkg::DATA_W-1] ? cxrms_pkg::DATA_W'(-xr) : xr;
  assign rmag = rs_q[cxrms_pkg::RS_W-1] ? cxrms_pkg::RS_W'(-rs_q) : rs_q;

  always_comb begin
    case (cmd_i.div_sel)
      cxrms_pkg::DIV_ELEM: begin
        div_num = cxrms_pkg::DIV_NUM_W'({xmag, 13'd0})
                + cxrms_pkg::DIV_NUM_W'(scale_q);
        div_den = {scale_q, 1'b0};
      end
      cxrms_pkg::DIV_MEAN: begin
        div_num = cxrms_pkg::DIV_NUM_W'(rmag) + cxrms_pkg::DIV_NUM_W'(m >> 1);
        div_den = cxrms_pkg::DIV_DEN_W'(m);
      end
      default: begin
        div_num = cxrms_pkg::DIV_NUM_W'(ss_q) + cxrms_pkg::DIV_NUM_W'(m >> 1);
        div_den = cxrms_pkg::DIV_DEN_W'(m);
      end
    endcase
  end

  cxrms_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  // digit-by-digit square root, one result bit per step
  logic [cxrms_pkg::SQ_W-1:0] op_q;
  logic [cxrms_pkg::SQ_W:0]   res_q;
  logic [cxrms_pkg::SQ_W-1:0] one_q;
  logic [cxrms_pkg::SQ_W:0]   trial;

  assign trial = res_q + {1'b0, one_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      op_q  <= quo[cxrms_pkg::SQ_W-1:0];
      res_q <= '0;
      one_q <= cxrms_pkg::SQ_W'(1) << (cxrms_pkg::SQ_W - 1);
    end else if (cmd_i.sqrt_step) begin
      if ({1'b0, op_q} >= trial) begin
        op_q  <= op_q - trial[cxrms_pkg::SQ_W-1:0];
        res_q <= (res_q >> 1) + {1'b0, one_q};
      end else begin
        res_q <= res_q >> 1;
      end
      one_q <= one_q >> 2;
    end
    if (cmd_i.sqrt_round)
      scale_q <= ({1'b0, op_q} > res_q) ? cxrms_pkg::DATA_W'(res_q + 1'b1)
                                        : res_q[cxrms_pkg::DATA_W-1:0];
  end

  logic zs;
  assign zs = (scale_q == '0);

  // result values
  logic signed [cxrms_pkg::DATA_W-1:0] el_val, rs_val;
  logic signed [cxrms_pkg::DATA_W+1:0] mean, cen;

  always_comb begin
    if (zs) el_val = '0;
    else if (!xr[cxrms_pkg::DATA_W-1])
      el_val = (quo > cxrms_pkg::DIV_NUM_W'(32767)) ? 16'sh7FFF
                                                     : quo[cxrms_pkg::DATA_W-1:0];
    else
      el_val = (quo > cxrms_pkg::DIV_NUM_W'(32768)) ? 16'sh8000
                                                     : cxrms_pkg::DATA_W'(-quo[16:0]);
    if (!ones_q) mean = '0;
    else if (rs_q[cxrms_pkg::RS_W-1]) mean = -$signed({1'b0, quo[16:0]});
    else mean = $signed({1'b0, quo[16:0]});
    cen = {{2{yr[cxrms_pkg::DATA_W-1]}}, yr} - mean;
    if (cen > 18'sd32767) rs_val = 16'sh7FFF;
    else if (cen < -18'sd32768) rs_val = 16'sh8000;
    else rs_val = cen[cxrms_pkg::DATA_W-1:0];
  end

  // output register
  logic out_valid_q;
  logic out_free;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.emit) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_kind_o <= cmd_i.emit_kind;
      out_last_o <= cmd_i.emit_last;
      case (cmd_i.emit_kind)
        cxrms_pkg::KIND_ELEM: begin
          out_value_o <= el_val;
          out_col_o   <= col_q;
          out_row_o   <= {1'b0, cmd_i.row};
          out_zs_o    <= zs;
          out_icp_o   <= 1'b0;
        end
        cxrms_pkg::KIND_SCALE: begin
          out_value_o <= scale_q;
          out_col_o   <= col_q;
          out_row_o   <= '0;
          out_zs_o    <= zs;
          out_icp_o   <= 1'b0;
        end
        default: begin
          out_value_o <= rs_val;
          out_col_o   <= '0;
          out_row_o   <= {1'b0, cmd_i.row};
          out_zs_o    <= 1'b0;
          out_icp_o   <= ones_q;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;

  assign sts_o.ends_col   = ends_col;
  assign sts_o.col_zero   = col_zero;
  assign sts_o.zero_scale = zs;
  assign sts_o.div_done   = div_done;
  assign sts_o.out_free   = out_free;
  assign sts_o.m_last     = row_q;

endmodule

// ===== src/cxrms_ctrl.sv =====
// ----------------------------------------------------------------------------
// cxrms_ctrl
// Sequencer: intake, mean square, root, per-element divides, result order.
// ----------------------------------------------------------------------------
module cxrms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  cxrms_pkg::sts_t sts_i,
  output cxrms_pkg::cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE    = 4'd0;
  localparam logic [3:0] ST_MS_GO   = 4'd1;
  localparam logic [3:0] ST_MS_WAIT = 4'd2;
  localparam logic [3:0] ST_SQRT    = 4'd3;
  localparam logic [3:0] ST_RND     = 4'd4;
  localparam logic [3:0] ST_EL_GO   = 4'd5;
  localparam logic [3:0] ST_EL_WAIT = 4'd6;
  localparam logic [3:0] ST_EL_PUT  = 4'd7;
  localparam logic [3:0] ST_SC_PUT  = 4'd8;
  localparam logic [3:0] ST_MN_GO   = 4'd9;
  localparam logic [3:0] ST_MN_WAIT = 4'd10;
  localparam logic [3:0] ST_RS_PUT  = 4'd11;

  logic [3:0]                  state_q, state_d;
  logic [cxrms_pkg::ROW_W-1:0] i_q, i_d;
  logic [3:0]                  cnt_q, cnt_d;

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.row = i_q;
    in_stall_o = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.ends_col) state_d = ST_MS_GO;
        end
      end
      ST_MS_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = cxrms_pkg::DIV_MS;
        state_d = ST_MS_WAIT;
      end
      ST_MS_WAIT: begin
        if (sts_i.div_done) begin
          cmd_o.sqrt_init = 1'b1;
          cnt_d   = '0;
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == 4'(cxrms_pkg::SQ_STEPS - 1)) state_d = ST_RND;
      end
      ST_RND: begin
        cmd_o.sqrt_round = 1'b1;
        i_d     = '0;
        state_d = ST_EL_GO;
      end
      ST_EL_GO: begin
        if (sts_i.zero_scale) begin
          state_d = ST_EL_PUT;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = cxrms_pkg::DIV_ELEM;
          state_d = ST_EL_WAIT;
        end
      end
      ST_EL_WAIT: begin
        if (sts_i.div_done) state_d = ST_EL_PUT;
      end
      ST_EL_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cxrms_pkg::KIND_ELEM;
          if (i_q == sts_i.m_last) begin
            state_d = ST_SC_PUT;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = ST_EL_GO;
          end
        end
      end
      ST_SC_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cxrms_pkg::KIND_SCALE;
          cmd_o.emit_last = !sts_i.col_zero;
          if (sts_i.col_zero) begin
            state_d = ST_MN_GO;
          end else begin
            cmd_o.col_done = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      ST_MN_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = cxrms_pkg::DIV_MEAN;
        state_d = ST_MN_WAIT;
      end
      ST_MN_WAIT: begin
        if (sts_i.div_done) begin
          i_d     = '0;
          state_d = ST_RS_PUT;
        end
      end
      ST_RS_PUT: begin
        cmd_o.div_sel = cxrms_pkg::DIV_MEAN;
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = cxrms_pkg::KIND_RESP;
          if (i_q == sts_i.m_last) begin
            cmd_o.emit_last = 1'b1;
            cmd_o.col_done  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            i_d = i_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cnt_q   <= cnt_d;
    end
  end

  // a result is only loaded into a free output slot
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> sts_i.out_free) else $error("result loaded into busy slot");

  // a divider start clears its done flag on the next cycle
  a_div_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> !sts_i.div_done) else $error("stale divider done");

  // the column wrap-up always returns to intake
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.col_done |=> (state_q == ST_IDLE && !cmd_o.emit))
    else $error("column close not followed by intake");

  // the column-closing beat is the last result of its column
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.col_done |-> (cmd_o.emit && cmd_o.emit_last))
    else $error("column closed without last result");

endmodule

// ===== test/column_rms_scale_and_center_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_rms_scale_and_center_top_tb
// Streams column-major sample matrices into the block and checks every result
// beat against an in-bench model of the RMS scaling and response centring.
// The bench opens with a short table of hand-picked beats and follows with
// random phases over several register settings and handshake pressures.
// ----------------------------------------------------------------------------
module column_rms_scale_and_center_top_tb;

  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned HOLD_CYCLES    = 600;

  typedef struct {
    logic [cxrms_pkg::KIND_W-1:0] kind;
    logic [15:0]       value;
    logic [7:0]        col;
    logic [4:0]        row;
    logic              zs;
    logic              icp;
    logic              last;
  } res_t;

  // directed row: rows setting, beat payload, and the scale we expect to see
  // where it is obvious by hand
  typedef struct {
    int          rows;
    logic [15:0] x;
    logic [15:0] y;
    bit          typed;
    logic [15:0] scale;
    logic        zs;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [cxrms_pkg::DATA_W-1:0] in_x_sample_i = '0;
  logic signed [cxrms_pkg::DATA_W-1:0] in_y_sample_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [cxrms_pkg::KIND_W-1:0] out_kind_o;
  logic signed [cxrms_pkg::DATA_W-1:0] out_value_o;
  logic [cxrms_pkg::COL_W-1:0] out_column_index_o;
  logic [cxrms_pkg::CNT_W-1:0] out_row_index_o;
  logic out_zero_scale_o, out_intercept_found_o, out_last_result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cxrms_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [cxrms_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  column_rms_scale_and_center_top u_dut (.*);

  always #10 clk_i = ~clk_i;

  // model state
  int unsigned rows_reg = 16, cols_reg = 1;
  int          col_samples [16];
  int          resp_samples[16];
  longint unsigned sq_acc = 0;
  longint          resp_acc = 0;
  int unsigned row_pos = 0, col_pos = 0;
  bit          ones_so_far = 1'b1;

  res_t        pending_q[$];
  int          errors = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          hold_len = 0;

  function automatic longint unsigned isqrt_rnd(longint unsigned v);
    longint unsigned r, b, t;
    r = 0;
    for (b = 64'd1 << 20; b != 0; b >>= 1) begin
      t = r + b;
      if (t * t <= v) r = t;
    end
    if (v - r * r > r) r++;
    return r;
  endfunction

  function automatic int sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  // advance the model by one accepted beat; queue what the beat causes
  task automatic rms_predict(input logic signed [15:0] x, input logic signed [15:0] y,
                             output bit closed, output logic [15:0] sc_o,
                             output logic zs_o);
    int unsigned n, p, idx, m;
    longint unsigned sc, mag, qm;
    longint mean;
    int q;
    bit zs, icp;
    res_t r;
    res_t burst[$];
    n = (rows_reg == 0) ? 1 : (rows_reg > 16 ? 16 : rows_reg);
    p = (cols_reg == 0) ? 1 : cols_reg;
    idx = (row_pos >= 16) ? 15 : row_pos;
    closed = 1'b0; sc_o = '0; zs_o = 1'b0;
    col_samples[idx] = x;
    sq_acc += longint'(x) * longint'(x);
    if (col_pos == 0) begin
      resp_samples[idx] = y;
      resp_acc += y;
      if (x != cxrms_pkg::ONE_Q88) ones_so_far = 1'b0;
    end
    m = idx + 1;
    if (m < n) begin
      row_pos = m;
      return;
    end
    closed = 1'b1;
    sc = isqrt_rnd((sq_acc + m / 2) / m);
    zs = (sc == 0);
    for (int i = 0; i < m; i++) begin
      q = 0;
      if (!zs) begin
        mag = longint'(col_samples[i] < 0 ? -col_samples[i] : col_samples[i]) * 4096;
        qm = (mag * 2 + sc) / (sc * 2);
        q = sat16(col_samples[i] < 0 ? -longint'(qm) : longint'(qm));
      end
      r = '{cxrms_pkg::KIND_ELEM, q[15:0], col_pos[7:0], i[4:0], zs, 1'b0, 1'b0};
      burst.push_back(r);
    end
    r = '{cxrms_pkg::KIND_SCALE, sc[15:0], col_pos[7:0], 5'd0, zs, 1'b0, 1'b0};
    burst.push_back(r);
    sc_o = sc[15:0]; zs_o = zs;
    if (col_pos == 0) begin
      icp = ones_so_far;
      mean = 0;
      if (icp) begin
        if (resp_acc >= 0) mean = (resp_acc + m / 2) / m;
        else mean = -((-resp_acc + m / 2) / m);
      end
      for (int i = 0; i < m; i++) begin
        q = sat16(longint'(resp_samples[i]) - mean);
        r = '{cxrms_pkg::KIND_RESP, q[15:0], 8'd0, i[4:0], 1'b0, icp, 1'b0};
        burst.push_back(r);
      end
      resp_acc = 0;
      ones_so_far = 1'b1;
    end
    burst[burst.size() - 1].last = 1'b1;
    foreach (burst[i]) pending_q.push_back(burst[i]);
    sq_acc = 0;
    row_pos = 0;
    col_pos = (col_pos + 1 >= p) ? 0 : col_pos + 1;
  endtask

  // one sample beat; called at a rising edge, returns at the accepting edge or after a random idle gap that follows it
  task automatic send_sample(input logic [15:0] x, input logic [15:0] y,
                             output bit closed, output logic [15:0] sc,
                             output logic zs);
    int gap;
    in_valid_i <= 1'b1;
    in_x_sample_i <= x;
    in_y_sample_i <= y;
    do @(posedge clk_i); while (in_stall_o);
    rms_predict(x, y, closed, sc, zs);
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // register write, only once the block has drained
  task automatic write_reg(input logic [cxrms_pkg::CFG_IDX_W-1:0] idx,
                           input logic [7:0] data);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    // a beat that closes nothing may still be in flight
    repeat (60) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == cxrms_pkg::CFG_ROWS) rows_reg = data & 8'h1F;
    else cols_reg = data;
    cfg_valid_i <= 1'b0;
  endtask

  // receiver: random stall, plus one long hold-off counted here
  int  hold_count = 0;
  bit  hold_done = 1'b0;
  always @(posedge clk_i) begin
    if (hold_len != 0 && !hold_done) begin
      out_stall_i <= 1'b1;
      hold_count++;
      if (hold_count >= hold_len) hold_done = 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result beat kind %0d value %0h", out_kind_o, out_value_o);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_kind_o !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_kind_o); errors++;
        end
        if (out_value_o !== e.value) begin
          $error("value: expected %0h actual %0h", e.value, out_value_o); errors++;
        end
        if (out_column_index_o !== e.col) begin
          $error("column_index: expected %0d actual %0d", e.col, out_column_index_o);
          errors++;
        end
        if (out_row_index_o !== e.row) begin
          $error("row_index: expected %0d actual %0d", e.row, out_row_index_o); errors++;
        end
        if (out_zero_scale_o !== e.zs) begin
          $error("zero_scale: expected %0b actual %0b", e.zs, out_zero_scale_o); errors++;
        end
        if (out_intercept_found_o !== e.icp) begin
          $error("intercept_found: expected %0b actual %0b", e.icp, out_intercept_found_o);
          errors++;
        end
        if (out_last_result_o !== e.last) begin
          $error("last_result: expected %0b actual %0b", e.last, out_last_result_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // pick a sample so that column zero often stays all ones
  int col_style = 0;
  function automatic logic [15:0] pick_x();
    case (col_style)
      0: return ($urandom_range(19) == 0) ? 16'($urandom) : cxrms_pkg::ONE_Q88;
      1: return 16'($signed($urandom_range(4)) - 2);
      2: return ($urandom_range(1) == 0) ? 16'h8000 : 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  dir_row_t dir_tab[] = '{
    // one row, two columns: each beat closes a column
    '{1, 16'h0000, 16'h0005, 1, 16'h0000, 1'b1},
    '{1, 16'h0100, 16'h0007, 1, 16'h0100, 1'b0},
    '{1, 16'h0100, 16'h8000, 1, 16'h0100, 1'b0},
    '{1, 16'h8000, 16'h7FFF, 1, 16'h8000, 1'b0},
    '{1, 16'h7FFF, 16'h0000, 1, 16'h7FFF, 1'b0},
    '{1, 16'hFFFF, 16'hFFFF, 1, 16'h0001, 1'b0},
    '{1, 16'h0001, 16'h7FFF, 1, 16'h0001, 1'b0},
    '{1, 16'h0000, 16'h8000, 1, 16'h0000, 1'b1},
    // three rows: all-ones column zero with centring that saturates
    '{3, 16'h0100, 16'h8000, 0, 16'h0, 1'b0},
    '{3, 16'h0100, 16'h7FFF, 0, 16'h0, 1'b0},
    '{3, 16'h0100, 16'h7FFF, 0, 16'h0, 1'b0},
    '{3, 16'h0001, 16'h0, 0, 16'h0, 1'b0},
    '{3, 16'hFFFF, 16'h0, 0, 16'h0, 1'b0},
    '{3, 16'h0000, 16'h0, 0, 16'h0, 1'b0},
    '{3, 16'h0100, 16'h8000, 0, 16'h0, 1'b0},
    '{3, 16'h0100, 16'h8000, 0, 16'h0, 1'b0},
    '{3, 16'h0100, 16'h7FFF, 0, 16'h0, 1'b0},
    '{3, 16'h8000, 16'h0, 0, 16'h0, 1'b0},
    '{3, 16'h7FFF, 16'h0, 0, 16'h0, 1'b0},
    '{3, 16'h8000, 16'h0, 0, 16'h0, 1'b0}
  };

  // random phases: rows, cols, beats
  int ph_rows[10] = '{16, 0, 31, 1, 5, 16, 2, 7, 0, 31};
  int ph_cols[10] = '{1, 3, 2, 0, 255, 2, 1, 4, 1, 3};
  int ph_len [10] = '{70, 30, 60, 30, 25, 70, 30, 40, 20, 55};

  initial begin
    bit closed;
    logic [15:0] sc;
    logic zs;
    int cur_rows;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table: rows=1, cols=2 to start
    write_reg(cxrms_pkg::CFG_COLS, 8'd2);
    cur_rows = -1;
    foreach (dir_tab[i]) begin
      if (dir_tab[i].rows != cur_rows) begin
        cur_rows = dir_tab[i].rows;
        write_reg(cxrms_pkg::CFG_ROWS, 8'(cur_rows));
        if (cur_rows == 3) write_reg(cxrms_pkg::CFG_COLS, 8'd2);
      end
      send_sample(dir_tab[i].x, dir_tab[i].y, closed, sc, zs);
      if (dir_tab[i].typed) begin
        if (!closed) begin
          $error("closed: expected %0b actual %0b", 1'b1, closed);
          errors++;
        end
        if (sc !== dir_tab[i].scale) begin
          $error("scale: expected %0h actual %0h", dir_tab[i].scale, sc);
          errors++;
        end
        if (zs !== dir_tab[i].zs) begin
          $error("zero_scale: expected %0b actual %0b", dir_tab[i].zs, zs);
          errors++;
        end
      end
    end

    // random phases; register writes often land mid-column on purpose
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(cxrms_pkg::CFG_ROWS,
                8'(ph_rows[ph]) | 8'({$urandom_range(7), 5'd0}));
      write_reg(cxrms_pkg::CFG_COLS,
                (ph == 9) ? 8'($urandom_range(255)) : 8'(ph_cols[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 6; stall_pct = 6; end
      endcase
      // long receiver hold-off while the sender keeps offering beats
      if (ph == 2) hold_len <= HOLD_CYCLES;
      for (int k = 0; k < ph_len[ph]; k++) begin
        if (row_pos == 0)
          col_style = (col_pos == 0 && $urandom_range(9) < 6) ? 0 : $urandom_range(3, 1);
        send_sample(pick_x(), 16'($urandom), closed, sc, zs);
      end
    end
    in_valid_i <= 1'b0;
    stall_pct = 20;

    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/cxrms_pkg.sv
src/cxrms_div.sv
src/cxrms_dp.sv
src/cxrms_ctrl.sv
src/column_rms_scale_and_center_top.sv
test/column_rms_scale_and_center_top_tb.sv
